[hdl/tbd_pkg.sv]
`default_nettype none
package tbd_pkg;

  localparam int NUM_BTN = 3;
  localparam int COORD_W = 10;
  localparam int TICK_W = 32;
  localparam int MASK_W = 3;
  localparam int IN_DATA_W = 56;
  localparam int OUT_DATA_W = 8;

  localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 32'd100;

  // mode codes carried on the input tuser bit
  localparam logic MODE_POLL = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  // button rectangles: index 0 back, 1 next, 2 play
  localparam logic [COORD_W-1:0] BTN_X0 [NUM_BTN] = '{10'd98, 10'd318, 10'd192};
  localparam logic [COORD_W-1:0] BTN_Y0 [NUM_BTN] = '{10'd172, 10'd172, 10'd156};
  localparam logic [COORD_W-1:0] BTN_W  [NUM_BTN] = '{10'd64, 10'd64, 10'd96};
  localparam logic [COORD_W-1:0] BTN_H  [NUM_BTN] = '{10'd64, 10'd64, 10'd96};

  typedef struct packed {
    logic               mode;
    logic [MASK_W-1:0]  take_mask;
    logic               touch_present;
    logic [COORD_W-1:0] touch_x;
    logic [COORD_W-1:0] touch_y;
    logic [TICK_W-1:0]  now_tick;
  } item_t;

  typedef struct packed {
    logic press_event;
    logic held;
  } btn_stat_t;

endpackage
`default_nettype wire

[hdl/tbd_button.sv]
`default_nettype none
module tbd_button #(
  parameter int BTN_IDX = 0
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      fire,
  input  wire tbd_pkg::item_t      item,
  input  wire [tbd_pkg::TICK_W-1:0] debounce_ticks,
  output tbd_pkg::btn_stat_t       stat
);
  import tbd_pkg::*;

  localparam logic [COORD_W-1:0] X_LO = BTN_X0[BTN_IDX];
  localparam logic [COORD_W-1:0] X_HI = BTN_X0[BTN_IDX] + BTN_W[BTN_IDX];
  localparam logic [COORD_W-1:0] Y_LO = BTN_Y0[BTN_IDX];
  localparam logic [COORD_W-1:0] Y_HI = BTN_Y0[BTN_IDX] + BTN_H[BTN_IDX];

  logic              pressed_r, pressed_nxt;
  logic              pending_r, pending_nxt;
  logic [TICK_W-1:0] last_r, last_nxt;

  logic              hit;
  logic              mismatch;
  logic              accept_chg;
  logic              pending_upd;
  logic [TICK_W-1:0] elapsed;
  logic              is_take;

  always_comb begin
    is_take = (item.mode == MODE_TAKE);
    hit = item.touch_present &&
          (item.touch_x >= X_LO) && (item.touch_x <= X_HI) &&
          (item.touch_y >= Y_LO) && (item.touch_y <= Y_HI);
    mismatch = !is_take && (hit != pressed_r);
    // wrapping distance since the last mismatch
    elapsed = item.now_tick - last_r;
    accept_chg = mismatch && (elapsed >= debounce_ticks);

    pressed_nxt = accept_chg ? hit : pressed_r;
    pending_upd = pending_r | (accept_chg & hit);
    last_nxt = mismatch ? item.now_tick : last_r;

    if (is_take) begin
      pending_nxt = pending_r & ~item.take_mask[BTN_IDX];
    end else begin
      pending_nxt = pending_upd;
    end

    // flags are reported before the take clears them
    stat.press_event = pending_upd;
    stat.held = pressed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      pending_r <= 1'b0;
      last_r <= '0;
    end else if (fire) begin
      pressed_r <= pressed_nxt;
      pending_r <= pending_nxt;
      last_r <= last_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/touch_button_debouncer_core.sv]
`default_nettype none
// Debounced touch buttons (back, next, play) for a touch panel. Each input
// transaction is either a poll (tuser 0) carrying a touch sample and a tick
// count, or a take (tuser 1) that reports and clears the latched press flags
// selected by take_mask. Every transaction produces exactly one result
// transaction with the press flags and the debounced held states. A button
// changes state only if at least debounce_ticks have passed since its last
// mismatch. One transaction is accepted every cycle while the output is not
// stalled; each passes the input register, then the hit test and debounce
// compare into the result register. cfg writes are meant for idle time only.
module touch_button_debouncer_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // take_mask[2:0], touch_present[3], touch_x[13:4], touch_y[23:14],
  // now_tick[55:24]
  input  wire [tbd_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode[0]
  input  wire                               in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // back_event[0], next_event[1], play_event[2], back_held[3],
  // next_held[4], play_held[5], zero[7:6]
  output logic [tbd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire                               cfg_wr_en,
  input  wire [tbd_pkg::TICK_W-1:0]         cfg_wr_data
);
  import tbd_pkg::*;

  logic              in_v_r;
  item_t             in_item_r;
  item_t             in_item;
  logic              out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [TICK_W-1:0] dbnc_r;
  logic              advance;
  logic              fire;
  btn_stat_t         stat [NUM_BTN];

  always_comb begin
    in_item.mode = in_tuser;
    in_item.take_mask = in_tdata[2:0];
    in_item.touch_present = in_tdata[3];
    in_item.touch_x = in_tdata[13:4];
    in_item.touch_y = in_tdata[23:14];
    in_item.now_tick = in_tdata[55:24];
  end

  // result register moves when empty or drained
  assign advance = !out_v_r || out_tready;
  assign fire = in_v_r && advance;
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbnc_r <= DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      dbnc_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_item;
    end
  end

  for (genvar b = 0; b < NUM_BTN; b++) begin : g_btn
    tbd_button #(
      .BTN_IDX(b)
    ) u_btn (
      .clk           (clk),
      .rst_n         (rst_n),
      .fire          (fire),
      .item          (in_item_r),
      .debounce_ticks(dbnc_r),
      .stat          (stat[b])
    );
  end

  always_comb begin
    out_data_nxt = '0;
    for (int b = 0; b < NUM_BTN; b++) begin
      out_data_nxt[b] = stat[b].press_event;
      out_data_nxt[NUM_BTN + b] = stat[b].held;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_data_r;

endmodule
`default_nettype wire

[bench/touch_button_debouncer_core_test.sv]
module touch_button_debouncer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tbd_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   in_tuser = MODE_POLL;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [TICK_W-1:0]      cfg_wr_data = '0;

  touch_button_debouncer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // debouncer state as the bench sees it
  logic [TICK_W-1:0] hold_off = DEBOUNCE_RESET;
  logic              btn_down [NUM_BTN] = '{1'b0, 1'b0, 1'b0};
  logic              btn_flag [NUM_BTN] = '{1'b0, 1'b0, 1'b0};
  logic [TICK_W-1:0] btn_last_tick [NUM_BTN] = '{32'd0, 32'd0, 32'd0};

  item_t       touch_queue [$];
  logic [5:0]  expected_status [$];
  int          mismatches = 0;
  int          result_count = 0;
  logic [TICK_W-1:0] session_tick = '0;

  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit rx_hold_req = 1'b0;
  int tx_gap = 0;
  int rx_stall = 0;
  item_t tx_item;
  item_t rx_item;
  logic [5:0] want;

  string status_name [6] = '{"back_event", "next_event", "play_event",
                             "back_held", "next_held", "play_held"};

  // hit test, lockout debounce and flag latch for one transaction
  function automatic logic [5:0] debounce_sample(item_t it);
    logic [5:0]        status;
    logic              hit;
    logic [TICK_W-1:0] elapsed;
    for (int b = 0; b < NUM_BTN; b++) begin
      if (it.mode == MODE_POLL) begin
        hit = it.touch_present &&
              int'(it.touch_x) >= int'(BTN_X0[b]) &&
              int'(it.touch_x) <= int'(BTN_X0[b]) + int'(BTN_W[b]) &&
              int'(it.touch_y) >= int'(BTN_Y0[b]) &&
              int'(it.touch_y) <= int'(BTN_Y0[b]) + int'(BTN_H[b]);
        if (hit != btn_down[b]) begin
          elapsed = it.now_tick - btn_last_tick[b];
          if (elapsed >= hold_off) begin
            if (hit)
              btn_flag[b] = 1'b1;
            btn_down[b] = hit;
          end
          btn_last_tick[b] = it.now_tick;
        end
      end
    end
    for (int b = 0; b < NUM_BTN; b++) begin
      status[b] = btn_flag[b];
      status[NUM_BTN + b] = btn_down[b];
      if (it.mode == MODE_TAKE && it.take_mask[b])
        btn_flag[b] = 1'b0;
    end
    return status;
  endfunction

  function automatic item_t make_poll(logic present, int x, int y,
                                      logic [TICK_W-1:0] tick, logic [2:0] mask);
    item_t it;
    it.mode = MODE_POLL;
    it.take_mask = mask;
    it.touch_present = present;
    it.touch_x = COORD_W'(x);
    it.touch_y = COORD_W'(y);
    it.now_tick = tick;
    return it;
  endfunction

  // poll fields carry junk on a take
  function automatic item_t make_take(logic [2:0] mask);
    item_t it;
    it.mode = MODE_TAKE;
    it.take_mask = mask;
    it.touch_present = 1'($urandom_range(0, 1));
    it.touch_x = COORD_W'($urandom_range(0, 1023));
    it.touch_y = COORD_W'($urandom_range(0, 1023));
    it.now_tick = $urandom;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (touch_queue.size() > 0) begin
        tx_item = touch_queue.pop_front();
        in_tuser <= tx_item.mode;
        in_tdata <= {tx_item.now_tick, tx_item.touch_y, tx_item.touch_x,
                     tx_item.touch_present, tx_item.take_mask};
        in_tvalid <= 1'b1;
        tx_gap = tx_quiet ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: predicts on input transactions, checks output transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        rx_item.mode = in_tuser;
        rx_item.take_mask = in_tdata[2:0];
        rx_item.touch_present = in_tdata[3];
        rx_item.touch_x = in_tdata[13:4];
        rx_item.touch_y = in_tdata[23:14];
        rx_item.now_tick = in_tdata[55:24];
        expected_status.push_back(debounce_sample(rx_item));
      end
      if (out_tvalid && out_tready) begin
        result_count++;
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: unexpected transaction, tdata %h", result_count, out_tdata);
        end else begin
          want = expected_status.pop_front();
          for (int f = 0; f < 6; f++) begin
            if (out_tdata[f] !== want[f]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("result %0d: %s expected %0b got %0b", result_count,
                         status_name[f], want[f], out_tdata[f]);
            end
          end
        end
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_stall = 300;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_stall = rx_quiet ? 0 : pick_gap();
      end
    end
  end

  task automatic write_debounce(logic [TICK_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    hold_off = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do
      @(negedge clk);
    while (touch_queue.size() != 0 || in_tvalid || expected_status.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // finger sessions: mostly touches in or just around a button with a running tick
  task automatic touch_session(int count, int step_max);
    int r;
    int b;
    int x;
    int y;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 5)
        session_tick = $urandom;
      else
        session_tick += $urandom_range(0, step_max);
      if (r < 15) begin
        touch_queue.push_back(make_take(3'($urandom_range(0, 7))));
      end else if (r < 22) begin
        touch_queue.push_back(make_poll(1'b0, $urandom_range(0, 1023),
                                        $urandom_range(0, 1023), session_tick,
                                        3'($urandom_range(0, 7))));
      end else if (r < 35) begin
        touch_queue.push_back(make_poll(1'b1, $urandom_range(0, 1023),
                                        $urandom_range(0, 1023), session_tick,
                                        3'($urandom_range(0, 7))));
      end else begin
        b = $urandom_range(0, NUM_BTN - 1);
        x = int'(BTN_X0[b]) - 3 + $urandom_range(0, int'(BTN_W[b]) + 6);
        y = int'(BTN_Y0[b]) - 3 + $urandom_range(0, int'(BTN_H[b]) + 6);
        touch_queue.push_back(make_poll(1'b1, x, y, session_tick,
                                        3'($urandom_range(0, 7))));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: edges of each rectangle, lockout, takes, wrap of the tick
    tx_quiet = 1'b1;
    touch_queue.push_back(make_poll(1'b0, 100, 200, 32'd500, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 98, 172, 32'd1000, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 162, 236, 32'd1010, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 163, 236, 32'd1020, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 97, 172, 32'd1200, 3'd0));
    touch_queue.push_back(make_take(3'b000));
    touch_queue.push_back(make_poll(1'b1, 318, 172, 32'd2000, 3'b111));
    touch_queue.push_back(make_poll(1'b1, 382, 236, 32'd2050, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 382, 237, 32'd2300, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 192, 156, 32'd3000, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 288, 252, 32'd3001, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 289, 252, 32'd3500, 3'd0));
    touch_queue.push_back(make_take(3'b101));
    touch_queue.push_back(make_take(3'b111));
    touch_queue.push_back(make_poll(1'b1, 1023, 1023, 32'd4000, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 0, 0, 32'd4100, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 240, 200, 32'hFFFF_FFC0, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 0, 0, 32'h0000_0010, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 240, 200, 32'h0000_0020, 3'd0));
    touch_queue.push_back(make_poll(1'b0, 240, 200, 32'h0000_0090, 3'd0));
    touch_queue.push_back(make_take(3'b111));
    wait_drained();
    tx_quiet = 1'b0;

    // zero lockout: every mismatch goes through
    write_debounce('0);
    touch_session(90, 50);
    wait_drained();

    // maximum lockout: only an elapsed count of all ones passes
    write_debounce('1);
    touch_queue.push_back(make_poll(1'b1, 120, 200, 32'd5, 3'd0));
    touch_queue.push_back(make_poll(1'b1, 120, 200, 32'd4, 3'd0));
    touch_session(60, 150);
    wait_drained();

    // receiver holds off while the sender keeps offering
    write_debounce(32'd30);
    rx_hold_req = 1'b1;
    tx_quiet = 1'b1;
    touch_session(90, 60);
    wait_drained();
    tx_quiet = 1'b0;

    // a stretch with no idling on either side
    write_debounce($urandom_range(1, 400));
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    touch_session(90, 2 * int'(hold_off));
    wait_drained();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // back at the reset value, sender paused halfway until all results are in
    write_debounce(DEBOUNCE_RESET);
    touch_session(45, 200);
    wait_drained();
    touch_session(45, 200);
    wait_drained();

    if (mismatches == 0 && expected_status.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
